[rtl/core/srp_pkg.sv]
// shared types and constants of the socks5 request parser
package srp_pkg;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_CMD,
    PH_RSV,
    PH_ATYP,
    PH_RSV_X,
    PH_ATYP_X,
    PH_DLEN,
    PH_ADDR,
    PH_PHI,
    PH_PLO,
    PH_DONE
  } phase_t;

  localparam logic [2:0] ST_PEND = 3'd0;
  localparam logic [2:0] ST_ADDR = 3'd1;
  localparam logic [2:0] ST_OK   = 3'd2;
  localparam logic [2:0] ST_BAD  = 3'd3;
  localparam logic [2:0] ST_CMD  = 3'd4;
  localparam logic [2:0] ST_ATYP = 3'd5;

  localparam logic [3:0] REP_NONE = 4'h0;
  localparam logic [3:0] REP_CMD  = 4'h7;
  localparam logic [3:0] REP_ATYP = 4'h8;

  localparam logic [7:0] SOCKS_VER      = 8'h05;
  localparam logic [7:0] REQ_CONNECT    = 8'h01;
  localparam logic [7:0] ADDR_TYPE_V4   = 8'h01;
  localparam logic [7:0] ADDR_TYPE_NAME = 8'h03;
  localparam logic [7:0] ADDR_TYPE_V6   = 8'h04;

  localparam logic [1:0] KIND_IPV4   = 2'd0;
  localparam logic [1:0] KIND_DOMAIN = 2'd1;
  localparam logic [1:0] KIND_IPV6   = 2'd2;

  localparam logic [7:0] LEN_IPV4 = 8'd4;
  localparam logic [7:0] LEN_IPV6 = 8'd16;

  typedef struct packed {
    phase_t     phase;
    logic [1:0] kind;
    logic [7:0] bytes_left;
    logic [7:0] byte_pos;
    logic [7:0] port_hi;
  } srp_state_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  addr_byte;
    logic [7:0]  addr_index;
    logic [1:0]  addr_kind;
    logic [15:0] dest_port;
    logic [3:0]  reply_code;
  } srp_result_t;

endpackage

[rtl/core/srp_in_if.sv]
// request byte channel
interface srp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       first;
  logic       last;

  modport source (output valid, data_byte, first, last, input ready);
  modport sink (input valid, data_byte, first, last, output ready);
endinterface

[rtl/core/srp_out_if.sv]
// parse result channel
interface srp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [7:0]  addr_byte;
  logic [7:0]  addr_index;
  logic [1:0]  addr_kind;
  logic [15:0] dest_port;
  logic [3:0]  reply_code;

  modport source (output valid, status, addr_byte, addr_index, addr_kind, dest_port,
                  reply_code, input ready);
  modport sink (input valid, status, addr_byte, addr_index, addr_kind, dest_port,
                reply_code, output ready);
endinterface

[rtl/core/srp_step.sv]
// one parser step: next state and result for one request byte
module srp_step
  import srp_pkg::*;
(
  input  srp_state_t  state,
  input  logic [7:0]  data_byte,
  input  logic        first,
  input  logic        last,
  output srp_state_t  state_next,
  output srp_result_t result
);

  always_comb begin
    state_next = state;
    result     = '0;
    result.status     = ST_PEND;
    result.reply_code = REP_NONE;

    if (first) begin
      state_next.kind       = KIND_IPV4;
      state_next.bytes_left = '0;
      state_next.byte_pos   = '0;
      state_next.port_hi    = '0;
      if (data_byte != SOCKS_VER || last) begin
        result.status    = ST_BAD;
        state_next.phase = PH_DONE;
      end else begin
        state_next.phase = PH_CMD;
      end
    end else begin
      case (state.phase)
        PH_CMD: begin
          if (last) begin
            result.status    = ST_BAD;
            state_next.phase = PH_DONE;
          end else begin
            state_next.phase = (data_byte == REQ_CONNECT) ? PH_RSV : PH_RSV_X;
          end
        end
        PH_RSV, PH_RSV_X: begin
          if (last) begin
            result.status    = ST_BAD;
            state_next.phase = PH_DONE;
          end else begin
            state_next.phase = (state.phase == PH_RSV) ? PH_ATYP : PH_ATYP_X;
          end
        end
        PH_ATYP_X: begin
          // command check deferred until the header is complete
          result.status     = ST_CMD;
          result.reply_code = REP_CMD;
          state_next.phase  = PH_DONE;
        end
        PH_ATYP: begin
          state_next.byte_pos = '0;
          case (data_byte)
            ADDR_TYPE_V4: begin
              state_next.kind       = KIND_IPV4;
              state_next.bytes_left = LEN_IPV4;
              state_next.phase      = PH_ADDR;
            end
            ADDR_TYPE_NAME: begin
              state_next.kind  = KIND_DOMAIN;
              state_next.phase = PH_DLEN;
            end
            ADDR_TYPE_V6: begin
              state_next.kind       = KIND_IPV6;
              state_next.bytes_left = LEN_IPV6;
              state_next.phase      = PH_ADDR;
            end
            default: begin
              result.status     = ST_ATYP;
              result.reply_code = REP_ATYP;
              state_next.phase  = PH_DONE;
            end
          endcase
        end
        PH_DLEN: begin
          state_next.bytes_left = data_byte;
          // empty domain skips straight to the port
          state_next.phase = (data_byte == 8'd0) ? PH_PHI : PH_ADDR;
        end
        PH_ADDR: begin
          result.status         = ST_ADDR;
          result.addr_byte      = data_byte;
          result.addr_index     = state.byte_pos;
          result.addr_kind      = state.kind;
          state_next.byte_pos   = state.byte_pos + 8'd1;
          state_next.bytes_left = state.bytes_left - 8'd1;
          if (state.bytes_left == 8'd1) begin
            state_next.phase = PH_PHI;
          end
        end
        PH_PHI: begin
          state_next.port_hi = data_byte;
          state_next.phase   = PH_PLO;
        end
        PH_PLO: begin
          result.status    = ST_OK;
          result.addr_kind = state.kind;
          result.dest_port = {state.port_hi, data_byte};
          state_next.phase = PH_DONE;
        end
        default: begin
          // idle or done: byte ignored
        end
      endcase
    end
  end

endmodule

[rtl/core/socks5_request_parser.sv]
// socks5 connect request parser, top level
// a transferred byte passes the input register and then the result register
// one byte per cycle while rsp.ready holds; a new byte is taken while a result waits
// the parser state advances when a byte moves from the input to the result register
// rst (synchronous) empties both registers and returns the parser to idle
module socks5_request_parser
  import srp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  srp_in_if.sink      req,
  srp_out_if.source   rsp
);

  logic        s1_valid;
  logic [7:0]  s1_data;
  logic        s1_first;
  logic        s1_last;
  logic        s1_advance;

  srp_state_t  state;
  srp_state_t  state_next;
  srp_result_t step_result;

  logic        out_valid;
  srp_result_t out_result;

  assign s1_advance = s1_valid && (!out_valid || rsp.ready);
  assign req.ready  = !s1_valid || s1_advance;

  srp_step u_step (
    .state      (state),
    .data_byte  (s1_data),
    .first      (s1_first),
    .last       (s1_last),
    .state_next (state_next),
    .result     (step_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
      state     <= '{phase: PH_IDLE, kind: KIND_IPV4, bytes_left: '0, byte_pos: '0,
                     port_hi: '0};
    end else begin
      if (req.ready) begin
        s1_valid <= req.valid;
      end
      if (s1_advance) begin
        state     <= state_next;
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      s1_data  <= req.data_byte;
      s1_first <= req.first;
      s1_last  <= req.last;
    end
    if (s1_advance) begin
      out_result <= step_result;
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.status     = out_result.status;
  assign rsp.addr_byte  = out_result.addr_byte;
  assign rsp.addr_index = out_result.addr_index;
  assign rsp.addr_kind  = out_result.addr_kind;
  assign rsp.dest_port  = out_result.dest_port;
  assign rsp.reply_code = out_result.reply_code;

  // an address byte is only read while at least one is still owed
  a_addr_count: assert property (@(posedge clk) disable iff (rst)
    state.phase == PH_ADDR |-> state.bytes_left != 8'd0)
    else $error("address phase with no bytes left");

  // each reply code goes with its own error status and nothing else
  a_reply: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((out_result.reply_code == REP_CMD) == (out_result.status == ST_CMD)) &&
                  ((out_result.reply_code == REP_ATYP) == (out_result.status == ST_ATYP)))
    else $error("reply code does not match status");

  // a first byte that is not version 5 closes the request
  a_bad_ver: assert property (@(posedge clk) disable iff (rst)
    s1_advance && s1_first && s1_data != SOCKS_VER |=>
      state.phase == PH_DONE && out_valid && out_result.status == ST_BAD)
    else $error("bad version not rejected");

  // a completed port only leaves the parser done
  a_done: assert property (@(posedge clk) disable iff (rst)
    s1_advance && !s1_first && state.phase == PH_PLO |=>
      state.phase == PH_DONE && out_result.status == ST_OK)
    else $error("port completion lost");

  // the input register only backpressures while it holds a byte
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !req.ready |-> s1_valid && out_valid)
    else $error("input stalled while empty");

endmodule

[bench/socks5_request_checker.sv]
// result checker of the socks5 request parser: predicts each result and compares it
`timescale 1ns / 100ps

module socks5_request_checker
  import srp_pkg::*;
(
  input  logic clk,
  input  logic rst,
  srp_in_if    req,
  srp_out_if   rsp,
  output int   failures,
  output int   outstanding
);

  phase_t      parse_phase;
  logic [1:0]  parse_kind;
  logic [7:0]  addr_left;
  logic [7:0]  addr_pos;
  logic [15:0] port_acc;

  srp_result_t due_results[$];
  srp_result_t want;

  function automatic srp_result_t parse_step(input logic [7:0] b, input logic first,
                                             input logic last);
    srp_result_t r;
    r = '0;
    r.status = ST_PEND;
    r.reply_code = REP_NONE;
    if (first) begin
      // a first byte restarts from any phase
      parse_kind = KIND_IPV4;
      addr_left = 8'd0;
      addr_pos = 8'd0;
      port_acc = 16'd0;
      if (b != SOCKS_VER || last) begin
        r.status = ST_BAD;
        parse_phase = PH_DONE;
      end else begin
        parse_phase = PH_CMD;
      end
    end else begin
      case (parse_phase)
        PH_CMD: begin
          if (last) begin
            r.status = ST_BAD;
            parse_phase = PH_DONE;
          end else begin
            parse_phase = (b == REQ_CONNECT) ? PH_RSV : PH_RSV_X;
          end
        end
        PH_RSV, PH_RSV_X: begin
          // header must not end early, checked before the command
          if (last) begin
            r.status = ST_BAD;
            parse_phase = PH_DONE;
          end else begin
            parse_phase = (parse_phase == PH_RSV) ? PH_ATYP : PH_ATYP_X;
          end
        end
        PH_ATYP_X: begin
          r.status = ST_CMD;
          r.reply_code = REP_CMD;
          parse_phase = PH_DONE;
        end
        PH_ATYP: begin
          addr_pos = 8'd0;
          case (b)
            ADDR_TYPE_V4: begin
              parse_kind = KIND_IPV4;
              addr_left = LEN_IPV4;
              parse_phase = PH_ADDR;
            end
            ADDR_TYPE_NAME: begin
              parse_kind = KIND_DOMAIN;
              parse_phase = PH_DLEN;
            end
            ADDR_TYPE_V6: begin
              parse_kind = KIND_IPV6;
              addr_left = LEN_IPV6;
              parse_phase = PH_ADDR;
            end
            default: begin
              r.status = ST_ATYP;
              r.reply_code = REP_ATYP;
              parse_phase = PH_DONE;
            end
          endcase
        end
        PH_DLEN: begin
          addr_left = b;
          parse_phase = (b == 8'd0) ? PH_PHI : PH_ADDR;
        end
        PH_ADDR: begin
          r.status = ST_ADDR;
          r.addr_byte = b;
          r.addr_index = addr_pos;
          r.addr_kind = parse_kind;
          addr_pos = addr_pos + 8'd1;
          addr_left = addr_left - 8'd1;
          if (addr_left == 8'd0) parse_phase = PH_PHI;
        end
        PH_PHI: begin
          port_acc = {b, 8'h00};
          parse_phase = PH_PLO;
        end
        PH_PLO: begin
          port_acc = {port_acc[15:8], b};
          r.status = ST_OK;
          r.addr_kind = parse_kind;
          r.dest_port = port_acc;
          parse_phase = PH_DONE;
        end
        default: ;
      endcase
    end
    return r;
  endfunction

  task automatic check_field(input string what, input int exp_val, input int act_val);
    if (exp_val != act_val) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, exp_val, act_val);
      failures++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      parse_phase = PH_IDLE;
      parse_kind = KIND_IPV4;
      addr_left = 8'd0;
      addr_pos = 8'd0;
      port_acc = 16'd0;
      due_results.delete();
      failures = 0;
    end else begin
      // compare first: a byte taken now cannot show up in the same cycle
      if (rsp.valid && rsp.ready) begin
        if (due_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual status %0d", $time,
                   rsp.status);
          failures++;
        end else begin
          want = due_results.pop_front();
          check_field("status", want.status, rsp.status);
          check_field("addr_byte", want.addr_byte, rsp.addr_byte);
          check_field("addr_index", want.addr_index, rsp.addr_index);
          check_field("addr_kind", want.addr_kind, rsp.addr_kind);
          check_field("dest_port", want.dest_port, rsp.dest_port);
          check_field("reply_code", want.reply_code, rsp.reply_code);
        end
      end
      if (req.valid && req.ready)
        due_results = {due_results, parse_step(req.data_byte, req.first, req.last)};
    end
    outstanding = due_results.size();
  end

endmodule

[bench/socks5_request_parser_test.sv]
// top of the socks5 request parser test: clock, reset, byte stimulus and verdict
`timescale 1ns / 100ps

module socks5_request_parser_test
  import srp_pkg::*;
();

  localparam int RANDOM_ITEMS = 850;
  localparam int WATCHDOG_LIMIT = 2000;

  logic clk;
  logic rst;
  int   failures;
  int   outstanding;
  int   items_sent;
  int   idle_cycles;
  bit   burst;

  srp_in_if  req_ch ();
  srp_out_if rsp_ch ();

  socks5_request_parser DUT (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  socks5_request_checker checker_i (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch),
    .failures(failures),
    .outstanding(outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] pick_byte();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hff;
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic first, input logic last);
    int gap;
    gap = burst ? 0 : pick_gap();
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.data_byte <= b;
    req_ch.first <= first;
    req_ch.last <= last;
    do @(posedge clk); while (!req_ch.ready);
    @(negedge clk);
  endtask

  task automatic send_request();
    logic [7:0] msg[$];
    logic [7:0] atyp;
    logic       end_chunk;
    int         len;
    int         cut;
    int         n;
    burst = ($urandom_range(0, 3) == 0);
    msg = {msg, (($urandom_range(0, 99) < 4) ? pick_byte() : SOCKS_VER)};
    msg = {msg, (($urandom_range(0, 99) < 10) ? pick_byte() : REQ_CONNECT)};
    msg = {msg, pick_byte()};
    n = $urandom_range(0, 99);
    if (n < 30) atyp = ADDR_TYPE_V4;
    else if (n < 60) atyp = ADDR_TYPE_NAME;
    else if (n < 88) atyp = ADDR_TYPE_V6;
    else atyp = pick_byte();
    msg = {msg, atyp};
    len = 0;
    if (atyp == ADDR_TYPE_V4) begin
      len = int'(LEN_IPV4);
    end else if (atyp == ADDR_TYPE_V6) begin
      len = int'(LEN_IPV6);
    end else if (atyp == ADDR_TYPE_NAME) begin
      n = $urandom_range(0, 99);
      if (n < 4) len = 255;
      else if (n < 14) len = 0;
      else if (n < 18) len = $urandom_range(100, 254);
      else len = $urandom_range(1, 12);
      msg = {msg, 8'(len)};
    end
    repeat (len) msg = {msg, pick_byte()};
    msg = {msg, pick_byte()};
    msg = {msg, pick_byte()};
    // now and then the next request cuts this one short
    cut = msg.size();
    if ($urandom_range(0, 99) < 8) cut = $urandom_range(1, msg.size() - 1);
    for (n = 0; n < cut; n++) begin
      end_chunk = (n < 3) ? ($urandom_range(0, 99) < 3) : ($urandom_range(0, 99) < 12);
      send_byte(msg[n], n == 0, end_chunk);
    end
    items_sent += cut;
    // stray bytes that belong to no request
    if ($urandom_range(0, 9) == 0)
      repeat ($urandom_range(1, 4)) send_byte(pick_byte(), 1'b0, 1'($urandom_range(0, 1)));
  endtask

  // result side back-pressure, with calm stretches of no stall
  initial begin : result_sink
    int stall_left;
    int calm_left;
    int roll;
    rsp_ch.ready = 1'b0;
    stall_left = 0;
    calm_left = 0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        rsp_ch.ready <= 1'b0;
        stall_left--;
      end else if (calm_left > 0) begin
        rsp_ch.ready <= 1'b1;
        calm_left--;
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < 3) begin
          rsp_ch.ready <= 1'b1;
          calm_left = $urandom_range(30, 150);
        end else if (roll < 30) begin
          rsp_ch.ready <= 1'b0;
          stall_left = pick_gap();
        end else begin
          rsp_ch.ready <= 1'b1;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.data_byte = 8'h00;
    req_ch.first = 1'b0;
    req_ch.last = 1'b0;
    items_sent = 0;
    idle_cycles = 0;
    burst = 1'b0;
    repeat (5) @(negedge clk);
    rst <= 1'b0;

    // byte while idle is ignored
    send_byte(8'haa, 1'b0, 1'b0);
    // bad version, then a byte ignored after the error
    send_byte(8'h04, 1'b1, 1'b0);
    send_byte(8'hff, 1'b0, 1'b1);
    // chunk ends on the version byte
    send_byte(SOCKS_VER, 1'b1, 1'b1);
    // chunk ends on the command byte
    send_byte(SOCKS_VER, 1'b1, 1'b0);
    send_byte(REQ_CONNECT, 1'b0, 1'b1);
    // unsupported command
    send_byte(SOCKS_VER, 1'b1, 1'b0);
    send_byte(8'h02, 1'b0, 1'b0);
    send_byte(8'h00, 1'b0, 1'b0);
    send_byte(ADDR_TYPE_V4, 1'b0, 1'b0);
    // unknown address type
    send_byte(SOCKS_VER, 1'b1, 1'b0);
    send_byte(REQ_CONNECT, 1'b0, 1'b0);
    send_byte(8'h00, 1'b0, 1'b0);
    send_byte(8'h02, 1'b0, 1'b0);
    // empty domain, chunk end after the header, top port
    send_byte(SOCKS_VER, 1'b1, 1'b0);
    send_byte(REQ_CONNECT, 1'b0, 1'b0);
    send_byte(8'hff, 1'b0, 1'b0);
    send_byte(ADDR_TYPE_NAME, 1'b0, 1'b1);
    send_byte(8'h00, 1'b0, 1'b0);
    send_byte(8'hff, 1'b0, 1'b0);
    send_byte(8'hff, 1'b0, 1'b0);

    while (items_sent < RANDOM_ITEMS) send_request();
    req_ch.valid <= 1'b0;

    wait (outstanding == 0);
    repeat (8) @(posedge clk);
    if (failures == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
